### src/cfsc_pkg.sv
package cfsc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 25;
    localparam int FREQ_W     = 7;
    localparam int CCOUNT_W   = 7;
    localparam int COEFF_MAXN = 64;
    localparam int PROD_W     = 2 * SAMPLE_W;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // register indexes on the config port
    localparam logic REG_COEFF_COUNT = 1'b0;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Q1.15 sine of a 32-bit phase, Taylor series through x^11 in Q30
    function automatic logic signed [SAMPLE_W-1:0] sine_q15(input logic [31:0] phase);
        logic [1:0]      quad;
        longint unsigned r, x, x2, t;
        longint          sum, v;
        quad = phase[31:30];
        r    = {34'd0, phase[29:0]};
        if (quad[0]) begin
            r = 64'h4000_0000 - r;
        end
        x   = (r * PI_HALF_Q30) >> 30;
        x2  = (x * x) >> 30;
        sum = longint'(x);
        t   = ((x * x2) >> 30) / 64'd6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        sum = sum - longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        v = longint'((longint'(sum) * 64'd32767 + 64'd536870912) >>> 30);
        if (v > 32767) begin
            v = 32767;
        end
        if (quad[1]) begin
            v = -v;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

### src/complex_fourier_series_coeffs.sv
// Channel   | Dir | Word
// s_axis    | in  | one point: tdata x, y; tlast ends the set
// m_axis    | out | one coefficient: tdata re, im, frequency; tlast on the final one
// apb       | in  | coeff_count at byte address 0
//
// Points load one per cycle while idle. The point flagged last starts a run and
// the block is not ready until the final coefficient is taken. Each coefficient
// uses one shared serial divider (range reduction, twiddle step, two scalings)
// and one shared 16x16 multiplier, four products per point. Reset is
// synchronous; a stalled output word holds and adds its stall cycles to the run.
module complex_fourier_series_coeffs #(
    parameter int MAX_POINTS = 256,
    parameter int TABLE_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_x [15:0], sample_y [31:16]
    input  logic        s_axis_tlast,   // sample_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // coef_re [24:0], coef_im [49:25], frequency [56:50]
    output logic        m_axis_tlast,   // coef_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfsc_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int KI    = $clog2(TABLE_SIZE);
    localparam int KW    = KI + 2;
    localparam int ACC_W = PROD_W + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MODW, S_STEP, S_STEPW, S_RD, S_MAC,
        S_DRE, S_DREW, S_DIM, S_DIMW, S_OUT
    } t_state;

    t_state                     r_state;
    logic [CCOUNT_W-1:0]        r_ccount;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              r_m;
    logic [5:0]                 r_i;
    logic [5:0]                 r_last_i;
    logic [5:0]                 r_nmag;
    logic                       r_neg;
    logic [CW-1:0]              r_nm;
    logic [KW-1:0]              r_qs;
    logic [CW-1:0]              r_rs;
    logic [AW-1:0]              r_j;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              r_rem;
    logic [KW-1:0]              r_k;
    logic [2:0]                 r_ph;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_re;
    logic signed [ACC_W-1:0]    r_im;
    logic [31:0]                r_pt;
    logic [31:0]                r_mem [MAX_POINTS];
    logic signed [COEF_W-1:0]   r_ore;
    logic signed [COEF_W-1:0]   r_oim;
    logic signed [FREQ_W-1:0]   r_ofreq;
    logic                       r_olast;

    logic                       w_wr;
    logic                       w_in_acc;
    logic                       w_start;
    logic [ACC_W-1:0]           w_dvd;
    logic [ACC_W-1:0]           w_dvs;
    logic                       w_done;
    logic [ACC_W-1:0]           w_quot;
    logic [ACC_W-1:0]           w_rem;
    logic signed [SAMPLE_W-1:0] w_cos;
    logic signed [SAMPLE_W-1:0] w_sin;
    logic signed [SAMPLE_W-1:0] w_x;
    logic signed [SAMPLE_W-1:0] w_y;
    logic signed [SAMPLE_W-1:0] w_opa;
    logic signed [SAMPLE_W-1:0] w_opb;
    logic [ACC_W-1:0]           w_mag_re;
    logic [ACC_W-1:0]           w_mag_im;
    logic [CW-1:0]              w_rmod;
    logic [CW:0]                w_idx_n;
    logic [CW:0]                w_rem_n;
    logic [KW-1:0]              w_k_n;
    logic [CW-1:0]              w_idx_f;
    logic [CW-1:0]              w_rem_f;
    logic [KW-1:0]              w_k_f;
    logic [6:0]                 w_cc;
    logic signed [COEF_W-1:0]   w_sat;

    // config port
    assign pready   = 1'b1;
    assign w_wr     = psel & penable & pwrite & (paddr == {REG_COEFF_COUNT, 2'b00});
    assign prdata   = (paddr == {REG_COEFF_COUNT, 2'b00}) ? 32'(r_ccount) : 32'd0;
    assign w_in_acc = s_axis_tvalid & s_axis_tready;

    // clamp coefficient count to 1..64
    always_comb begin
        if (r_ccount == '0) begin
            w_cc = 7'd1;
        end else if (r_ccount > 7'(COEFF_MAXN)) begin
            w_cc = 7'(COEFF_MAXN);
        end else begin
            w_cc = r_ccount;
        end
    end

    // shared divider operands
    assign w_mag_re = r_re[ACC_W-1] ? ACC_W'(-r_re) : ACC_W'(r_re);
    assign w_mag_im = r_im[ACC_W-1] ? ACC_W'(-r_im) : ACC_W'(r_im);
    assign w_start  = (r_state == S_MOD) || (r_state == S_STEP) ||
                      (r_state == S_DRE) || (r_state == S_DIM);

    always_comb begin
        unique case (r_state)
            S_MOD:   w_dvd = ACC_W'(r_nmag);
            S_STEP:  w_dvd = ACC_W'(r_nm) * ACC_W'(TABLE_SIZE);
            S_DRE:   w_dvd = w_mag_re + (ACC_W'(r_m) << 6);
            default: w_dvd = w_mag_im + (ACC_W'(r_m) << 6);
        endcase
        if (r_state == S_MOD || r_state == S_STEP) begin
            w_dvs = ACC_W'(r_m);
        end else begin
            w_dvs = ACC_W'(r_m) << 7;
        end
    end

    cfsc_div #(.W(ACC_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    cfsc_trig_rom #(.TABLE_SIZE(TABLE_SIZE)) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_k[KI-1:0]),
        .o_cos  (w_cos),
        .o_sin  (w_sin)
    );

    // point store, registered read
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_cnt < CW'(MAX_POINTS)) begin
            r_mem[r_cnt[AW-1:0]] <= s_axis_tdata;
        end
        r_pt <= r_mem[r_j];
    end

    // multiplier operands per phase
    assign w_x = r_pt[15:0];
    assign w_y = r_pt[31:16];
    always_comb begin
        case (r_ph)
            3'd0:    begin w_opa = w_x; w_opb = w_cos; end
            3'd1:    begin w_opa = w_y; w_opb = w_sin; end
            3'd2:    begin w_opa = w_y; w_opb = w_cos; end
            default: begin w_opa = w_x; w_opb = w_sin; end
        endcase
    end

    // twiddle index advance: idx*TS = k*M + rem kept exact
    assign w_rmod  = w_rem[CW-1:0];
    assign w_idx_n = {1'b0, r_idx} + {1'b0, r_nm};
    assign w_rem_n = {1'b0, r_rem} + {1'b0, r_rs};
    assign w_k_n   = r_k + r_qs;
    always_comb begin
        w_rem_f = w_rem_n[CW-1:0];
        w_k_f   = w_k_n;
        if (w_rem_n >= {1'b0, r_m}) begin
            w_rem_f = CW'(w_rem_n - {1'b0, r_m});
            w_k_f   = w_k_n + 1'b1;
        end
        w_idx_f = w_idx_n[CW-1:0];
        if (w_idx_n >= {1'b0, r_m}) begin
            w_idx_f = CW'(w_idx_n - {1'b0, r_m});
            w_k_f   = w_k_f - KW'(TABLE_SIZE);
        end
    end

    // sign and saturate a rounded quotient
    always_comb begin
        logic neg;
        neg = (r_state == S_DREW) ? r_re[ACC_W-1] : r_im[ACC_W-1];
        if (!neg) begin
            w_sat = (w_quot > ACC_W'(COEF_MAX)) ? COEF_MAX : COEF_W'(w_quot);
        end else begin
            w_sat = (w_quot > ACC_W'(COEF_MAX) + 1'b1) ? COEF_MIN : COEF_W'(-w_quot);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ccount <= 7'(COEFF_MAXN);
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_ccount <= pwdata[CCOUNT_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_m   <= r_cnt + 1'b1;
                        end else begin
                            r_m   <= r_cnt;
                        end
                        if (s_axis_tlast) begin
                            r_i      <= '0;
                            r_last_i <= 6'(w_cc - 7'd1);
                            r_nmag   <= '0;
                            r_neg    <= 1'b0;
                            r_state  <= S_MOD;
                        end
                    end
                end
                S_MOD:  r_state <= S_MODW;
                S_MODW: begin
                    if (w_done) begin
                        r_nm    <= (r_neg && w_rmod != '0) ? r_m - w_rmod : w_rmod;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: r_state <= S_STEPW;
                S_STEPW: begin
                    if (w_done) begin
                        r_qs    <= KW'(w_quot);
                        r_rs    <= w_rmod;
                        r_j     <= '0;
                        r_idx   <= '0;
                        r_rem   <= '0;
                        r_k     <= '0;
                        r_re    <= '0;
                        r_im    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_ph    <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_prod <= w_opa * w_opb;
                    r_ph   <= r_ph + 1'b1;
                    case (r_ph) inside
                        3'd1, 3'd2: r_re <= r_re + ACC_W'(r_prod);
                        3'd3:       r_im <= r_im + ACC_W'(r_prod);
                        3'd4:       r_im <= r_im - ACC_W'(r_prod);
                        default:    ;
                    endcase
                    if (r_ph == 3'd4) begin
                        r_idx <= w_idx_f;
                        r_rem <= w_rem_f;
                        r_k   <= w_k_f;
                        r_j   <= r_j + 1'b1;
                        r_state <= ({1'b0, r_j} == CW'(r_m - 1'b1)) ? S_DRE : S_RD;
                    end
                end
                S_DRE:  r_state <= S_DREW;
                S_DREW: begin
                    if (w_done) begin
                        r_ore   <= w_sat;
                        r_state <= S_DIM;
                    end
                end
                S_DIM:  r_state <= S_DIMW;
                S_DIMW: begin
                    if (w_done) begin
                        r_oim   <= w_sat;
                        r_ofreq <= r_neg ? -FREQ_W'(r_nmag) : FREQ_W'(r_nmag);
                        r_olast <= (r_i == r_last_i);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_i == r_last_i) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_nmag  <= 6'((7'(r_i) + 7'd2) >> 1);
                            r_neg   <= r_i[0];
                            r_state <= S_MOD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_ofreq, r_oim, r_ore};
    assign m_axis_tlast  = r_olast;

endmodule

### src/cfsc_div.sv
module cfsc_div #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_d;
    logic [W:0]       r_r;
    logic [W:0]       w_trial;
    logic             w_fit;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_r[W-1:0], r_q[W-1]};
    assign w_fit   = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r <= w_fit ? (w_trial - {1'b0, r_d}) : w_trial;
                r_q <= {r_q[W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[W-1:0];

endmodule

### src/cfsc_trig_rom.sv
module cfsc_trig_rom #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                                 i_clk,
    input  logic [$clog2(TABLE_SIZE)-1:0]        i_addr,
    output logic signed [cfsc_pkg::SAMPLE_W-1:0] o_cos,
    output logic signed [cfsc_pkg::SAMPLE_W-1:0] o_sin
);
    import cfsc_pkg::*;

    logic signed [SAMPLE_W-1:0] w_sin [TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] w_cos [TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] r_sin;
    logic signed [SAMPLE_W-1:0] r_cos;

    // constant tables, phase = k * 2^32 / TABLE_SIZE
    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_tab
        localparam logic [31:0] PH = 32'((64'(k) << 32) / TABLE_SIZE);
        assign w_sin[k] = sine_q15(PH);
        assign w_cos[k] = sine_q15(PH + 32'h4000_0000);
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_sin <= w_sin[i_addr];
        r_cos <= w_cos[i_addr];
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfsc_pkg::*;

    localparam int NPTS      = 256;
    localparam int TSIZE     = 1024;
    localparam int WD_LIMIT  = 40000;
    localparam int N_RANDOM  = 110;

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        logic signed [FREQ_W-1:0] freq;
        logic                     last;
    } t_coef;

    // Coefficient predictor and store of pending coefficients
    class t_coef_board;
        logic [31:0] pts [NPTS];
        int          npts;
        int          ncoef;
        t_coef       pending [$];
        int          errors;
        int          seen;

        function new();
            npts   = 0;
            ncoef  = 64;
            errors = 0;
            seen   = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endfunction

        // Q15 sine of a 32-bit phase, Taylor series in Q30
        function longint sin15(logic [31:0] ph);
            longint unsigned r, x, x2, t;
            longint          acc, v;
            int              m;
            r = ph[29:0];
            if (ph[30]) r = 64'h4000_0000 - r;
            x   = (r * 64'd1686629713) >> 30;
            x2  = (x * x) >> 30;
            t   = x;
            acc = x;
            for (m = 1; m <= 5; m++) begin
                t = ((t * x2) >> 30) / longint'((2 * m) * (2 * m + 1));
                acc = (m % 2) ? acc - longint'(t) : acc + longint'(t);
            end
            if (acc < 0) acc = 0;
            v = (acc * 32767 + (64'd1 << 29)) >>> 30;
            if (v > 32767) v = 32767;
            return ph[31] ? -v : v;
        endfunction

        function logic signed [COEF_W-1:0] scale(longint a, longint d);
            longint mag, q;
            mag = (a < 0) ? -a : a;
            q   = (mag + d / 2) / d;
            if (a < 0) q = -q;
            if (q > longint'(COEF_MAX)) q = COEF_MAX;
            if (q < longint'(COEF_MIN)) q = COEF_MIN;
            return q[COEF_W-1:0];
        endfunction

        function void set_count(logic [CCOUNT_W-1:0] v);
            ncoef = (v == 0) ? 1 : (v > COEFF_MAXN) ? COEFF_MAXN : v;
        endfunction

        // accepted point; the set's last point yields the coefficients
        function void note_point(logic [31:0] d, logic last);
            int          i, j, n, nm, idx;
            longint      re, im, c, s, x, y, k;
            logic [31:0] ph;
            t_coef       e;
            if (npts < NPTS) begin
                pts[npts] = d;
                npts++;
            end
            if (!last) return;
            for (i = 0; i < ncoef; i++) begin
                n  = ((i + 1) / 2) * ((i % 2) ? 1 : -1);
                nm = ((n % npts) + npts) % npts;
                re = 0;
                im = 0;
                for (j = 0; j < npts; j++) begin
                    idx = (nm * j) % npts;
                    k   = (longint'(idx) * TSIZE) / npts;
                    ph  = 32'((k << 32) / TSIZE);
                    s   = sin15(ph);
                    c   = sin15(ph + 32'h4000_0000);
                    x   = $signed(pts[j][15:0]);
                    y   = $signed(pts[j][31:16]);
                    re += x * c + y * s;
                    im += y * c - x * s;
                end
                e.re   = scale(re, longint'(npts) * 128);
                e.im   = scale(im, longint'(npts) * 128);
                e.freq = n[FREQ_W-1:0];
                e.last = (i + 1 == ncoef);
                pending.push_back(e);
            end
            npts = 0;
        endfunction

        function void check(logic [63:0] d, logic last);
            t_coef e;
            seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected coefficient %h", d));
                return;
            end
            e = pending.pop_front();
            if (d[24:0] !== e.re)
                report($sformatf("re got %0d exp %0d", $signed(d[24:0]), e.re));
            if (d[49:25] !== e.im)
                report($sformatf("im got %0d exp %0d", $signed(d[49:25]), e.im));
            if (d[56:50] !== e.freq)
                report($sformatf("freq got %0d exp %0d", $signed(d[56:50]), e.freq));
            if (last !== e.last)
                report($sformatf("last got %b exp %b (freq %0d)", last, e.last, e.freq));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;   // sample_x [15:0], sample_y [31:16]
    logic        s_axis_tlast = 0;   // sample_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;       // coef_re [24:0], coef_im [49:25], frequency [56:50]
    logic        m_axis_tlast;       // coef_last
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    t_coef_board board = new();
    int        idle_cycles = 0;
    int        sets_done = 0;
    bit        calm_src = 0;
    bit        calm_sink = 0;

    complex_fourier_series_coeffs uut (.*);

    always #6 i_clk = ~i_clk;

    // monitors: note accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_point(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired, %0d coefficients outstanding", board.pending.size());
            $display("complex_fourier_series_coeffs verification failed");
            $finish;
        end
    end

    // result sink with random stalls
    initial begin
        int gap;
        bit ok;
        @(posedge i_rst_n);
        forever begin
            gap = calm_sink ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                ok = m_axis_tvalid;
                @(posedge i_clk);
            end while (!ok);
        end
    end

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
        int gap;
        bit ok;
        gap = calm_src ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // wait for the run to drain, then write the coefficient count
    task automatic write_count(logic [CCOUNT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0 || !s_axis_tready) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * REG_COEFF_COUNT);
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_count(v);
    endtask

    task automatic send_set(int n);
        int j;
        for (j = 0; j < n; j++)
            send_point(16'($urandom), 16'($urandom), j == n - 1);
        sets_done++;
    endtask

    initial begin
        int sent, n, w;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single point at reset count, field extremes
        send_point(16'sh7fff, -16'sh8000, 1'b1);
        write_count(1);
        send_point(-16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b1);
        // zero count behaves as one, oversized count as the maximum
        write_count(0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh0001, -16'sh0001, 1'b1);
        write_count(127);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 1'b1);
        write_count(64);
        send_set(3);
        // full store: the dropped last point still starts the run
        write_count(3);
        calm_src = 1;
        for (n = 0; n < NPTS; n++)
            send_point(16'($urandom), 16'($urandom), 1'b0);
        calm_src = 0;
        send_point(16'sh1234, -16'sh1234, 1'b1);

        // random sets, mostly small, count changed between some sets
        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 2) == 0) begin
                w = $urandom_range(0, 3);
                write_count(w == 0 ? 1 : w == 1 ? 64 : $urandom_range(1, 64));
            end
            calm_src  = ($urandom_range(0, 3) == 0);
            calm_sink = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_set(n);
            sent += n;
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (board.pending.size() != 0 || !s_axis_tready) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d point sets loaded, %0d coefficients checked, including a full store",
                 sets_done, board.seen);
        $display("coefficient counts covered from one to the maximum, out of range included");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("complex_fourier_series_coeffs verification clean");
        else
            $display("complex_fourier_series_coeffs verification failed");
        $finish;
    end
endmodule

### files.f
src/cfsc_pkg.sv
src/cfsc_div.sv
src/cfsc_trig_rom.sv
src/complex_fourier_series_coeffs.sv
tb/testbench.sv
